FILE: hw/rtl/nva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note voice allocator package
// Sizes, codes, the shared map update type and the note replay rate table.
// ----------------------------------------------------------------------------
package nva_pkg;

  // Pool sizes.
  localparam int CHANNEL_COUNT = 64;
  localparam int NOTE_COUNT    = 128;

  // Fixed field widths of the event and result transactions.
  localparam int NOTE_W    = 7;
  localparam int CHANNEL_W = 6;
  localparam int RATE_W    = 18;
  localparam int ACTION_W  = 2;

  // Index widths that follow from the pool sizes.
  localparam int CHAN_IDX_W = $clog2(CHANNEL_COUNT);
  localparam int NOTE_IDX_W = $clog2(NOTE_COUNT);

  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } opcode_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  // One map update, shared by the note map and the channel pool.
  typedef struct packed {
    logic                  start;
    logic                  stop;
    logic [NOTE_IDX_W-1:0] note;
    logic [CHAN_IDX_W-1:0] chan;
  } upd_t;

  // Result of looking a note up in the note map.
  typedef struct packed {
    logic                  assigned;
    logic [CHAN_IDX_W-1:0] chan;
  } lookup_t;

  // Note frequency times sixteen, rounded down.
  localparam logic [RATE_W-1:0] RATE_TABLE [128] = '{
    18'd130,    18'd138,    18'd146,    18'd155,    18'd164,    18'd174,
    18'd184,    18'd195,    18'd207,    18'd220,    18'd233,    18'd246,
    18'd261,    18'd277,    18'd293,    18'd311,    18'd329,    18'd349,
    18'd369,    18'd391,    18'd415,    18'd440,    18'd466,    18'd493,
    18'd523,    18'd554,    18'd587,    18'd622,    18'd659,    18'd698,
    18'd739,    18'd783,    18'd830,    18'd880,    18'd932,    18'd987,
    18'd1046,   18'd1108,   18'd1174,   18'd1244,   18'd1318,   18'd1396,
    18'd1479,   18'd1567,   18'd1661,   18'd1760,   18'd1864,   18'd1975,
    18'd2093,   18'd2217,   18'd2349,   18'd2489,   18'd2637,   18'd2793,
    18'd2959,   18'd3135,   18'd3322,   18'd3520,   18'd3729,   18'd3951,
    18'd4186,   18'd4434,   18'd4698,   18'd4978,   18'd5274,   18'd5587,
    18'd5919,   18'd6271,   18'd6644,   18'd7040,   18'd7458,   18'd7902,
    18'd8372,   18'd8869,   18'd9397,   18'd9956,   18'd10548,  18'd11175,
    18'd11839,  18'd12543,  18'd13289,  18'd14080,  18'd14917,  18'd15804,
    18'd16744,  18'd17739,  18'd18794,  18'd19912,  18'd21096,  18'd22350,
    18'd23679,  18'd25087,  18'd26579,  18'd28160,  18'd29834,  18'd31608,
    18'd33488,  18'd35479,  18'd37589,  18'd39824,  18'd42192,  18'd44701,
    18'd47359,  18'd50175,  18'd53159,  18'd56320,  18'd59668,  18'd63217,
    18'd66976,  18'd70958,  18'd75178,  18'd79648,  18'd84384,  18'd89402,
    18'd94718,  18'd100350, 18'd106318, 18'd112640, 18'd119337, 18'd126434,
    18'd133952, 18'd141917, 18'd150356, 18'd159297, 18'd168769, 18'd178804,
    18'd189437, 18'd200701
  };

endpackage

FILE: hw/rtl/nva_owner_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note voice allocator note map
// Per-note assigned flags in flip-flops and the owning channel in a memory
// with a registered read, forwarded when the entry was written on the same edge.
// ----------------------------------------------------------------------------
module nva_owner_map (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [nva_pkg::NOTE_IDX_W-1:0] rd_note,
  input  wire logic [nva_pkg::NOTE_IDX_W-1:0] lookup_note,
  input  wire nva_pkg::upd_t                  upd,
  output nva_pkg::lookup_t                    lookup
);

  logic [nva_pkg::NOTE_COUNT-1:0] assigned;
  logic [nva_pkg::CHAN_IDX_W-1:0] chan_mem [nva_pkg::NOTE_COUNT];
  logic [nva_pkg::CHAN_IDX_W-1:0] rd_data;
  logic                           fwd_hit;
  logic [nva_pkg::CHAN_IDX_W-1:0] fwd_chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      assigned <= '0;
    end else if (upd.start) begin
      assigned[upd.note] <= 1'b1;
    end else if (upd.stop) begin
      assigned[upd.note] <= 1'b0;
    end
  end

  // The read sees the old contents when the same entry is written on this edge.
  always_ff @(posedge clk) begin
    if (upd.start) begin
      chan_mem[upd.note] <= upd.chan;
    end
    rd_data <= chan_mem[rd_note];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= upd.start && (upd.note == rd_note);
    end
    fwd_chan <= upd.chan;
  end

  assign lookup.assigned = assigned[lookup_note];
  assign lookup.chan     = fwd_hit ? fwd_chan : rd_data;

endmodule
`default_nettype wire

FILE: hw/rtl/nva_channel_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note voice allocator channel pool
// Busy bitmap of the channels and a priority encoder for the lowest free one.
// ----------------------------------------------------------------------------
module nva_channel_pool (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nva_pkg::upd_t                  upd,
  output logic                               free_found,
  output logic [nva_pkg::CHAN_IDX_W-1:0]      free_chan
);

  logic [nva_pkg::CHANNEL_COUNT-1:0] chan_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_busy <= '0;
    end else if (upd.start) begin
      chan_busy[upd.chan] <= 1'b1;
    end else if (upd.stop) begin
      chan_busy[upd.chan] <= 1'b0;
    end
  end

  // Scanning downwards leaves the lowest free channel selected.
  always_comb begin
    free_found = 1'b0;
    free_chan  = '0;
    for (int i = nva_pkg::CHANNEL_COUNT - 1; i >= 0; i--) begin
      if (!chan_busy[i]) begin
        free_found = 1'b1;
        free_chan  = nva_pkg::CHAN_IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/note_voice_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note voice allocator
// Maps note-on and note-off events onto a pool of synthesizer channels,
// first free channel first, and issues start and stop commands.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   -----------------------------------
//   event     start / busy         opcode, note_number, velocity
//   command   done (one cycle)     action, channel, replay_rate
//
// Every event transaction produces exactly one command transaction. Its done
// pulse comes from the command register, which follows the event register,
// and lasts one cycle. A new event is taken on every cycle: the note map,
// the busy bitmap with its priority encoder and the rate table are all
// resolved between the event register and the command register, so busy
// stays low. Reset is synchronous and clears the assigned flags and the busy
// bitmap directly; no clearing pass is needed. The receiver cannot stall.
//
// Velocity is taken with the event but has no effect on the command.
// ----------------------------------------------------------------------------
module note_voice_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          opcode,
  input  wire logic [nva_pkg::NOTE_W-1:0]     note_number,
  input  wire logic [nva_pkg::NOTE_W-1:0]     velocity,
  output logic                               done,
  output logic [nva_pkg::ACTION_W-1:0]        action,
  output logic [nva_pkg::CHANNEL_W-1:0]       channel,
  output logic [nva_pkg::RATE_W-1:0]          replay_rate
);

  // Event register.
  logic                           item_valid;
  logic                           op_q;
  logic [nva_pkg::NOTE_W-1:0]     note_q;

  // Decision logic.
  nva_pkg::lookup_t               lookup;
  nva_pkg::upd_t                  upd;
  logic                           free_found;
  logic [nva_pkg::CHAN_IDX_W-1:0] free_chan;
  logic                           note_ok;
  logic                           is_off;
  nva_pkg::action_t               action_next;

  logic accept;

  // The pipeline never backs up, so an event is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
    if (accept) begin
      op_q   <= opcode;
      note_q <= note_number;
    end
  end

  // The note map reads its channel memory with the incoming note, so the
  // registered read lines up with the event register.
  nva_owner_map u_owner_map (
    .clk         (clk),
    .rst         (rst),
    .rd_note     (note_number[nva_pkg::NOTE_IDX_W-1:0]),
    .lookup_note (note_q[nva_pkg::NOTE_IDX_W-1:0]),
    .upd         (upd),
    .lookup      (lookup)
  );

  nva_channel_pool u_channel_pool (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .free_found (free_found),
    .free_chan  (free_chan)
  );

  // A note outside the table of notes gets an empty command (a seven-bit note never is).
  assign note_ok = (32'(note_q) < nva_pkg::NOTE_COUNT);
  assign is_off  = (op_q == nva_pkg::OP_NOTE_OFF);

  // A note-on takes a channel only if the note is silent and a channel is
  // free; a note-off releases the channel of a sounding note.
  always_comb begin
    upd.start = item_valid && note_ok && !is_off && !lookup.assigned && free_found;
    upd.stop  = item_valid && note_ok && is_off && lookup.assigned;
    upd.note  = note_q[nva_pkg::NOTE_IDX_W-1:0];
    upd.chan  = upd.start ? free_chan : lookup.chan;
    if (upd.start) begin
      action_next = nva_pkg::ACT_START;
    end else if (upd.stop) begin
      action_next = nva_pkg::ACT_STOP;
    end else begin
      action_next = nva_pkg::ACT_NONE;
    end
  end

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
    action      <= action_next;
    channel     <= (upd.start || upd.stop) ? nva_pkg::CHANNEL_W'(upd.chan) : '0;
    replay_rate <= upd.start ? nva_pkg::RATE_TABLE[note_q] : '0;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/nva_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note voice allocator checker
// Port-level checks on command timing and command contents.
// ----------------------------------------------------------------------------
module nva_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [nva_pkg::ACTION_W-1:0]   action,
  input wire logic [nva_pkg::CHANNEL_W-1:0]  channel,
  input wire logic [nva_pkg::RATE_W-1:0]     replay_rate
);

  // Each event transaction yields its command once it has passed the event register and the command register.
  a_cmd_follows_event: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("event not followed by a command");

  a_no_spurious_cmd: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##2 !done)
    else $error("command without an event");

  a_none_is_empty: assert property (@(posedge clk) disable iff (rst)
    (done && action == nva_pkg::ACT_NONE) |-> (channel == '0 && replay_rate == '0))
    else $error("empty command carries a channel or rate");

  a_rate_on_start_only: assert property (@(posedge clk) disable iff (rst)
    done |-> ((action == nva_pkg::ACT_START) == (replay_rate != '0)))
    else $error("replay rate does not match the action");

endmodule

bind note_voice_allocator nva_checker u_nva_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .action      (action),
  .channel     (channel),
  .replay_rate (replay_rate)
);
`default_nettype wire
